// File: hdl/hit_polar_coordinates_and_delta_phi_unit_defines.svh
// assertion macros for the hit polar coordinates unit
// used by the top level only; expects signals clock and reset in scope
`ifndef HIT_POLAR_COORDINATES_AND_DELTA_PHI_UNIT_DEFINES_SVH
`define HIT_POLAR_COORDINATES_AND_DELTA_PHI_UNIT_DEFINES_SVH

// same-cycle implication
`define HPC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HPC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/hpc_pkg.sv
// shared types, widths, latencies and the arctangent table
// of the hit polar coordinates unit; no dependencies
package hpc_pkg;

   localparam int COORD_BITS = 20;
   localparam int ANGLE_BITS = 16;
   localparam int ITER       = 31;
   localparam int CW         = 64;
   localparam int SCALE_SH   = 60 - COORD_BITS;
   localparam int SQ_W       = 2 * COORD_BITS + 2;
   localparam int ANG_LAT    = ITER + 2;
   localparam int SQ_LAT     = COORD_BITS + 2;
   localparam int ALIGN      = (ANG_LAT > SQ_LAT) ? ANG_LAT : SQ_LAT;
   localparam int RAD_DLY    = ALIGN - SQ_LAT;
   localparam int ANG_DLY    = ALIGN - ANG_LAT;

   localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
   localparam logic [31:0] ROUND_HALF = 32'd1 << (31 - ANGLE_BITS);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] a_x;
      logic signed [COORD_BITS-1:0] a_y;
      logic signed [COORD_BITS-1:0] a_z;
      logic signed [COORD_BITS-1:0] b_x;
      logic signed [COORD_BITS-1:0] b_y;
      logic signed [COORD_BITS-1:0] b_z;
   } req_type;

   typedef struct packed {
      logic        [COORD_BITS-1:0] radius_3d;
      logic        [COORD_BITS-1:0] radius_transverse;
      logic signed [ANGLE_BITS-1:0] azimuth;
      logic signed [ANGLE_BITS-1:0] azimuth_difference;
      logic signed [ANGLE_BITS-1:0] azimuth_change;
   } rsp_type;

   // atan(2^-idx) in turn units, 2^32 = full turn
   function automatic logic [31:0] atan_turn(input int unsigned idx);
      logic [31:0] t;
      case (idx)
         0: t = 32'h20000000;
         1: t = 32'h12E4051E;
         2: t = 32'h09FB385B;
         3: t = 32'h051111D4;
         4: t = 32'h028B0D43;
         5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;
         7: t = 32'h00517C55;
         8: t = 32'h0028BE53;
         9: t = 32'h00145F2F;
         10: t = 32'h000A2F98;
         11: t = 32'h000517CC;
         12: t = 32'h00028BE6;
         13: t = 32'h000145F3;
         14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;
         16: t = 32'h000028BE;
         17: t = 32'h0000145F;
         18: t = 32'h00000A30;
         19: t = 32'h00000518;
         20: t = 32'h0000028C;
         21: t = 32'h00000146;
         22: t = 32'h000000A3;
         23: t = 32'h00000051;
         24: t = 32'h00000029;
         25: t = 32'h00000014;
         26: t = 32'h0000000A;
         27: t = 32'h00000005;
         28: t = 32'h00000003;
         29: t = 32'h00000001;
         30: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

endpackage

// File: hdl/hpc_cordic.sv
// pipelined vectoring cordic: azimuth of (x, y) rounded to the angle width
// one iteration per stage; uses hpc_pkg
module hpc_cordic (
   input  logic                                 clock,
   input  logic                                 en,
   input  logic signed [hpc_pkg::COORD_BITS:0]  x_in,
   input  logic signed [hpc_pkg::COORD_BITS:0]  y_in,
   output logic signed [hpc_pkg::ANGLE_BITS-1:0] angle
);

   logic signed [hpc_pkg::CW-1:0] x_ff [0:hpc_pkg::ITER];
   logic signed [hpc_pkg::CW-1:0] y_ff [0:hpc_pkg::ITER];
   logic        [31:0]            z_ff [0:hpc_pkg::ITER];
   logic                          zero_ff [0:hpc_pkg::ITER];
   logic signed [hpc_pkg::ANGLE_BITS-1:0] angle_ff;

   logic signed [hpc_pkg::CW-1:0] xs;
   logic signed [hpc_pkg::CW-1:0] ys;
   logic        [31:0]            z_rnd;

   assign xs = {{(hpc_pkg::CW - hpc_pkg::COORD_BITS - 1){x_in[hpc_pkg::COORD_BITS]}}, x_in}
               <<< hpc_pkg::SCALE_SH;
   assign ys = {{(hpc_pkg::CW - hpc_pkg::COORD_BITS - 1){y_in[hpc_pkg::COORD_BITS]}}, y_in}
               <<< hpc_pkg::SCALE_SH;

   // fold left half plane onto the right one
   always_ff @(posedge clock) begin
      if (en) begin
         if (xs[hpc_pkg::CW-1]) begin
            x_ff[0] <= -xs;
            y_ff[0] <= -ys;
            z_ff[0] <= hpc_pkg::HALF_TURN;
         end else begin
            x_ff[0] <= xs;
            y_ff[0] <= ys;
            z_ff[0] <= 32'd0;
         end
         zero_ff[0] <= (x_in == '0) && (y_in == '0);
      end
   end

   for (genvar i = 0; i < hpc_pkg::ITER; i++) begin : g_iter
      logic signed [hpc_pkg::CW-1:0] dx;
      logic signed [hpc_pkg::CW-1:0] dy;
      assign dx = y_ff[i] >>> i;
      assign dy = x_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[i][hpc_pkg::CW-1]) begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + hpc_pkg::atan_turn(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - hpc_pkg::atan_turn(i);
            end
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   assign z_rnd = z_ff[hpc_pkg::ITER] + hpc_pkg::ROUND_HALF;

   always_ff @(posedge clock) begin
      if (en) begin
         if (zero_ff[hpc_pkg::ITER]) begin
            angle_ff <= '0;
         end else begin
            angle_ff <= z_rnd[31 -: hpc_pkg::ANGLE_BITS];
         end
      end
   end

   assign angle = angle_ff;

endmodule

// File: hdl/hpc_isqrt.sv
// pipelined rounded integer square root of a sum of up to three squares
// one result bit per stage; uses hpc_pkg
module hpc_isqrt (
   input  logic                           clock,
   input  logic                           en,
   input  logic [hpc_pkg::SQ_W-1:0]       sq_a,
   input  logic [hpc_pkg::SQ_W-1:0]       sq_b,
   input  logic [hpc_pkg::SQ_W-1:0]       sq_c,
   output logic [hpc_pkg::COORD_BITS-1:0] root
);

   logic [hpc_pkg::SQ_W-1:0]       rem_ff  [0:hpc_pkg::COORD_BITS];
   logic [hpc_pkg::SQ_W-1:0]       root_ff [0:hpc_pkg::COORD_BITS];
   logic [hpc_pkg::COORD_BITS-1:0] out_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= sq_a + sq_b + sq_c;
         root_ff[0] <= '0;
      end
   end

   for (genvar j = 0; j < hpc_pkg::COORD_BITS; j++) begin : g_bit
      localparam logic [hpc_pkg::SQ_W-1:0] BIT =
         hpc_pkg::SQ_W'(1) << (2 * (hpc_pkg::COORD_BITS - 1 - j));
      logic [hpc_pkg::SQ_W-1:0] trial;
      assign trial = root_ff[j] + BIT;
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[j] >= trial) begin
               rem_ff[j+1]  <= rem_ff[j] - trial;
               root_ff[j+1] <= (root_ff[j] >> 1) + BIT;
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j] >> 1;
            end
         end
      end
   end

   // round to nearest: remainder above root means past the half point
   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= root_ff[hpc_pkg::COORD_BITS][hpc_pkg::COORD_BITS-1:0]
                   + hpc_pkg::COORD_BITS'(rem_ff[hpc_pkg::COORD_BITS]
                                         > root_ff[hpc_pkg::COORD_BITS]);
      end
   end

   assign root = out_ff;

endmodule

// File: hdl/hit_polar_coordinates_and_delta_phi_unit.sv
// Hit polar coordinates unit: for each item of two hits A and B it returns the 3D and
// transverse radius of A, the azimuth of A, and the wrapped azimuth differences of B and
// of B-A against A. It takes one item every clock while the result is not stalled; the
// path from acceptance to the result register runs through the input register, the
// 31-stage CORDIC pipeline with its fold and rounding stages, and the output register.
// A stalled result stalls the whole pipeline in place.
// Depends on hpc_pkg, hpc_cordic, hpc_isqrt and the assertion macro header.
`include "hit_polar_coordinates_and_delta_phi_unit_defines.svh"

module hit_polar_coordinates_and_delta_phi_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hpc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hpc_pkg::rsp_type rsp_data
);

   localparam int C  = hpc_pkg::COORD_BITS;
   localparam int A  = hpc_pkg::ANGLE_BITS;
   localparam int RW = 2 * C;
   localparam int AW = 3 * A;

   logic en;

   logic                  vld_ff [0:hpc_pkg::ALIGN];
   logic [2*C-1:0]        sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [C-1:0]   ax_ff, ay_ff, bx_ff, by_ff;
   logic signed [C:0]     dx_ff, dy_ff;
   logic                  rsp_valid_ff;
   hpc_pkg::rsp_type      rsp_data_ff;

   logic signed [2*C-1:0] prod_x, prod_y, prod_z;
   logic signed [C:0]     dx_in, dy_in;

   logic [C-1:0]          r3, rt;
   logic signed [A-1:0]   pa, pb, pd;
   logic [RW-1:0]         rad_now, rad_out;
   logic [AW-1:0]         ang_now, ang_out;
   logic signed [A-1:0]   pa_o, pb_o, pd_o;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   assign prod_x = req_data.a_x * req_data.a_x;
   assign prod_y = req_data.a_y * req_data.a_y;
   assign prod_z = req_data.a_z * req_data.a_z;
   assign dx_in  = {req_data.b_x[C-1], req_data.b_x} - {req_data.a_x[C-1], req_data.a_x};
   assign dy_in  = {req_data.b_y[C-1], req_data.b_y} - {req_data.a_y[C-1], req_data.a_y};

   always_ff @(posedge clock) begin
      if (en) begin
         sq_x_ff <= prod_x;
         sq_y_ff <= prod_y;
         sq_z_ff <= prod_z;
         ax_ff   <= req_data.a_x;
         ay_ff   <= req_data.a_y;
         bx_ff   <= req_data.b_x;
         by_ff   <= req_data.b_y;
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= hpc_pkg::ALIGN; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k <= hpc_pkg::ALIGN; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   hpc_isqrt u_sqrt_3d (
      .clock (clock),
      .en    (en),
      .sq_a  (hpc_pkg::SQ_W'(sq_x_ff)),
      .sq_b  (hpc_pkg::SQ_W'(sq_y_ff)),
      .sq_c  (hpc_pkg::SQ_W'(sq_z_ff)),
      .root  (r3)
   );

   hpc_isqrt u_sqrt_tr (
      .clock (clock),
      .en    (en),
      .sq_a  (hpc_pkg::SQ_W'(sq_x_ff)),
      .sq_b  (hpc_pkg::SQ_W'(sq_y_ff)),
      .sq_c  ('0),
      .root  (rt)
   );

   hpc_cordic u_cordic_a (
      .clock (clock),
      .en    (en),
      .x_in  ({ax_ff[C-1], ax_ff}),
      .y_in  ({ay_ff[C-1], ay_ff}),
      .angle (pa)
   );

   hpc_cordic u_cordic_b (
      .clock (clock),
      .en    (en),
      .x_in  ({bx_ff[C-1], bx_ff}),
      .y_in  ({by_ff[C-1], by_ff}),
      .angle (pb)
   );

   hpc_cordic u_cordic_d (
      .clock (clock),
      .en    (en),
      .x_in  (dx_ff),
      .y_in  (dy_ff),
      .angle (pd)
   );

   assign rad_now = {r3, rt};
   assign ang_now = {pa, pb, pd};

   if (hpc_pkg::RAD_DLY > 0) begin : g_rad_dly
      logic [RW-1:0] q_ff [0:hpc_pkg::RAD_DLY-1];
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[0] <= rad_now;
            for (int k = 1; k < hpc_pkg::RAD_DLY; k++) begin
               q_ff[k] <= q_ff[k-1];
            end
         end
      end
      assign rad_out = q_ff[hpc_pkg::RAD_DLY-1];
   end else begin : g_rad_thru
      assign rad_out = rad_now;
   end

   if (hpc_pkg::ANG_DLY > 0) begin : g_ang_dly
      logic [AW-1:0] q_ff [0:hpc_pkg::ANG_DLY-1];
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[0] <= ang_now;
            for (int k = 1; k < hpc_pkg::ANG_DLY; k++) begin
               q_ff[k] <= q_ff[k-1];
            end
         end
      end
      assign ang_out = q_ff[hpc_pkg::ANG_DLY-1];
   end else begin : g_ang_thru
      assign ang_out = ang_now;
   end

   assign pa_o = ang_out[AW-1 -: A];
   assign pb_o = ang_out[2*A-1 -: A];
   assign pd_o = ang_out[A-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= vld_ff[hpc_pkg::ALIGN];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff.radius_3d          <= rad_out[RW-1 -: C];
         rsp_data_ff.radius_transverse  <= rad_out[C-1:0];
         rsp_data_ff.azimuth            <= pa_o;
         rsp_data_ff.azimuth_difference <= pb_o - pa_o;
         rsp_data_ff.azimuth_change     <= pd_o - pa_o;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HPC_ASSERT_SAME(a_origin_phi, rsp_valid && (rsp_data.radius_transverse == '0), rsp_data.azimuth == '0, "nonzero azimuth at origin")
   `HPC_ASSERT_SAME(a_radius_order, rsp_valid, rsp_data.radius_3d >= rsp_data.radius_transverse, "3d radius below transverse radius")
   `HPC_ASSERT_NEXT(a_stall_hold, !en, $stable(vld_ff[0]) && $stable(vld_ff[hpc_pkg::ALIGN]), "pipeline moved during stall")

endmodule

// File: dv/hit_polar_coordinates_and_delta_phi_unit_tb.sv
// testbench for the hit polar coordinates unit: drives hit pairs, predicts radii and
// azimuth differences with its own cordic and integer square root, checks each result
// depends on hpc_pkg and the unit's rtl
`timescale 1ns / 100ps

module hit_polar_coordinates_and_delta_phi_unit_tb;

   localparam int N_RANDOM     = 600;
   localparam int WATCHDOG_MAX = 5000;
   localparam int LONG_STALL   = 300;
   localparam int N_TABLE      = 16;
   localparam logic signed [hpc_pkg::COORD_BITS-1:0] CMAX =
      {1'b0, {(hpc_pkg::COORD_BITS-1){1'b1}}};
   localparam logic signed [hpc_pkg::COORD_BITS-1:0] CMIN =
      {1'b1, {(hpc_pkg::COORD_BITS-1){1'b0}}};

   localparam logic [31:0] TURN_STEP [31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001};

   typedef struct {
      hpc_pkg::req_type hits;
      bit               has_exp;
      hpc_pkg::rsp_type exp;
   } hit_row_type;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   hpc_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   hpc_pkg::rsp_type rsp_data;

   hpc_pkg::rsp_type expected_geometry[$];
   hit_row_type      hit_table[N_TABLE];
   int               n_errors;
   int               n_sent;
   int               n_checked;
   int               idle_cycles;
   bit               stimulus_done;

   hit_polar_coordinates_and_delta_phi_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic logic [hpc_pkg::COORD_BITS-1:0] rounded_root(longint unsigned s);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned bitv;
      rem  = s;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      if (s - root * root > root) root++;
      return root[hpc_pkg::COORD_BITS-1:0];
   endfunction

   function automatic logic [hpc_pkg::ANGLE_BITS-1:0] hit_azimuth(longint x, longint y);
      logic [31:0] turn;
      logic [31:0] rounded;
      longint      dx;
      longint      dy;
      turn = 32'd0;
      if (x == 0 && y == 0) return '0;
      x = x <<< hpc_pkg::SCALE_SH;
      y = y <<< hpc_pkg::SCALE_SH;
      if (x < 0) begin
         x    = -x;
         y    = -y;
         turn = hpc_pkg::HALF_TURN;
      end
      for (int i = 0; i < 31; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y >= 0) begin
            x    = x + dx;
            y    = y - dy;
            turn = turn + TURN_STEP[i];
         end else begin
            x    = x - dx;
            y    = y + dy;
            turn = turn - TURN_STEP[i];
         end
      end
      rounded = turn + hpc_pkg::ROUND_HALF;
      return rounded[31 -: hpc_pkg::ANGLE_BITS];
   endfunction

   function automatic hpc_pkg::rsp_type predict_geometry(hpc_pkg::req_type h);
      hpc_pkg::rsp_type r;
      longint           ax;
      longint           ay;
      longint           az;
      longint           bx;
      longint           by;
      longint unsigned  sxy;
      logic [hpc_pkg::ANGLE_BITS-1:0] pa;
      ax  = h.a_x;
      ay  = h.a_y;
      az  = h.a_z;
      bx  = h.b_x;
      by  = h.b_y;
      sxy = ax * ax + ay * ay;
      pa  = hit_azimuth(ax, ay);
      r.radius_3d          = rounded_root(sxy + az * az);
      r.radius_transverse  = rounded_root(sxy);
      r.azimuth            = pa;
      r.azimuth_difference = hit_azimuth(bx, by) - pa;
      r.azimuth_change     = hit_azimuth(bx - ax, by - ay) - pa;
      return r;
   endfunction

   task automatic report_mismatch(string field, int idx, longint got, longint want);
      $display("mismatch item %0d %s: got %0d expected %0d", idx, field, got, want);
      n_errors++;
   endtask

   function automatic hpc_pkg::req_type random_hits();
      hpc_pkg::req_type h;
      int               mode;
      h    = hpc_pkg::req_type'({$urandom, $urandom, $urandom, 24'($urandom)});
      mode = $urandom_range(0, 7);
      if (mode == 0) begin
         h.a_x = hpc_pkg::COORD_BITS'($signed(11'($urandom)));
         h.a_y = hpc_pkg::COORD_BITS'($signed(11'($urandom)));
         h.b_x = hpc_pkg::COORD_BITS'($signed(11'($urandom)));
         h.b_y = hpc_pkg::COORD_BITS'($signed(11'($urandom)));
      end else if (mode == 1) begin
         h.b_x = h.a_x;
         h.b_y = h.a_y;
      end else if (mode == 2) begin
         h.a_x = $urandom_range(0, 1) ? CMAX : CMIN;
         h.a_y = $urandom_range(0, 1) ? CMAX : CMIN;
         h.a_z = $urandom_range(0, 1) ? CMAX : CMIN;
      end else if (mode == 3) begin
         h.a_y = '0;
         h.b_x = '0;
      end
      return h;
   endfunction

   function automatic hpc_pkg::req_type make_hits(longint ax, longint ay, longint az,
                                                  longint bx, longint by, longint bz);
      hpc_pkg::req_type h;
      h.a_x = hpc_pkg::COORD_BITS'(ax);
      h.a_y = hpc_pkg::COORD_BITS'(ay);
      h.a_z = hpc_pkg::COORD_BITS'(az);
      h.b_x = hpc_pkg::COORD_BITS'(bx);
      h.b_y = hpc_pkg::COORD_BITS'(by);
      h.b_z = hpc_pkg::COORD_BITS'(bz);
      return h;
   endfunction

   task automatic offer_hits(hpc_pkg::req_type h);
      req_valid <= 1'b1;
      req_data  <= h;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
      @(negedge clock);
   endtask

   task automatic random_gap();
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   initial begin
      hpc_pkg::rsp_type zero;
      zero = '0;
      hit_table[0]  = '{make_hits(0, 0, 0, 0, 0, 0), 1'b1, zero};
      hit_table[1]  = '{make_hits(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN), 1'b0, zero};
      hit_table[2]  = '{make_hits(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 1'b0, zero};
      hit_table[3]  = '{make_hits(CMIN, 0, 0, CMAX, 0, 0), 1'b0, zero};
      hit_table[4]  = '{make_hits(1, 0, 0, 0, 1, 0), 1'b0, zero};
      hit_table[5]  = '{make_hits(0, 1, 0, -1, 0, 0), 1'b0, zero};
      hit_table[6]  = '{make_hits(0, -1, 0, 0, 1, 0), 1'b0, zero};
      hit_table[7]  = '{make_hits(-1, 0, 0, 1, 0, 0), 1'b0, zero};
      hit_table[8]  = '{make_hits(-1, 1, 5, -1, 1, 7), 1'b0, zero};
      hit_table[9]  = '{make_hits(-1, -1, 0, -1, 1, 0), 1'b0, zero};
      hit_table[10] = '{make_hits(3, 4, 0, 3, 4, 0), 1'b0, zero};
      hit_table[11] = '{make_hits(CMAX, CMIN, 0, CMIN, CMAX, 0), 1'b0, zero};
      hit_table[12] = '{make_hits(0, 0, CMIN, 10, -10, 0), 1'b0, zero};
      hit_table[13] = '{make_hits(1000, 0, 0, 0, 0, 0), 1'b0, zero};
      hit_table[14] = '{make_hits(-CMAX, 1, 0, -CMAX, -1, 0), 1'b0, zero};
      hit_table[15] = '{make_hits(0, 0, 3, 0, 0, 4), 1'b1, zero};
      hit_table[15].exp.radius_3d = 3;
   end

   initial begin
      req_valid     = 1'b0;
      req_data      = '0;
      reset         = 1'b1;
      stimulus_done = 1'b0;
      n_sent        = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (hit_table[i]) begin
         expected_geometry.push_back(hit_table[i].has_exp ? hit_table[i].exp
                                     : predict_geometry(hit_table[i].hits));
         offer_hits(hit_table[i].hits);
      end
      for (int k = 0; k < N_RANDOM; k++) begin
         hpc_pkg::req_type h;
         h = random_hits();
         expected_geometry.push_back(predict_geometry(h));
         offer_hits(h);
         if (k == N_RANDOM / 2) begin
            req_valid <= 1'b0;
            while (expected_geometry.size() != 0) @(negedge clock);
         end else if (k > 60) begin
            random_gap();
         end
      end
      req_valid     <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (LONG_STALL) @(negedge clock);
      forever begin
         if (n_sent > 150 && n_sent < 400)
            rsp_ready <= ($urandom_range(0, 3) != 0);
         else
            rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      hpc_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_geometry.size() == 0) begin
            report_mismatch("unexpected item", n_checked, 0, 0);
         end else begin
            want = expected_geometry.pop_front();
            if (rsp_data.radius_3d !== want.radius_3d)
               report_mismatch("radius_3d", n_checked, rsp_data.radius_3d, want.radius_3d);
            if (rsp_data.radius_transverse !== want.radius_transverse)
               report_mismatch("radius_transverse", n_checked,
                               rsp_data.radius_transverse, want.radius_transverse);
            if (rsp_data.azimuth !== want.azimuth)
               report_mismatch("azimuth", n_checked, rsp_data.azimuth, want.azimuth);
            if (rsp_data.azimuth_difference !== want.azimuth_difference)
               report_mismatch("azimuth_difference", n_checked,
                               rsp_data.azimuth_difference, want.azimuth_difference);
            if (rsp_data.azimuth_change !== want.azimuth_change)
               report_mismatch("azimuth_change", n_checked,
                               rsp_data.azimuth_change, want.azimuth_change);
         end
         n_checked++;
      end
   end

   initial begin
      n_errors    = 0;
      n_checked   = 0;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_MAX) begin
            $display("watchdog expired, %0d items outstanding", expected_geometry.size());
            $display("Test completed with failures");
            $finish;
         end
         if (stimulus_done && expected_geometry.size() == 0) begin
            repeat (hpc_pkg::ANG_LAT + 8) @(posedge clock);
            $display("sent %0d hit pairs, checked %0d results incl. extremes, zero vectors,",
                     n_sent, n_checked);
            $display("equal hits, long output stall and drain pauses; %0d errors", n_errors);
            if (n_errors == 0)
               $display("Test completed successfully");
            else
               $display("Test completed with failures");
            $finish;
         end
      end
   end

endmodule
